/* design/simd_three_same_integer_alu_core_assert.svh */
// Assertion macros for the three-same integer SIMD core.
// Each macro expects clk and rst_n in scope.
`ifndef SIMD_THREE_SAME_INTEGER_ALU_CORE_ASSERT_SVH
`define SIMD_THREE_SAME_INTEGER_ALU_CORE_ASSERT_SVH

// Same-cycle implication
`define S3_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define S3_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/simd3_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// simd3_pkg
// Opcodes, lane helpers and the per-lane integer datapath function.
// ----------------------------------------------------------------------------
package simd3_pkg;

  localparam int VectorBytes = 16;

  // Three-same opcodes
  localparam logic [4:0] OP_HADD  = 5'h00;
  localparam logic [4:0] OP_QADD  = 5'h01;
  localparam logic [4:0] OP_RHADD = 5'h02;
  localparam logic [4:0] OP_LOGIC = 5'h03;
  localparam logic [4:0] OP_HSUB  = 5'h04;
  localparam logic [4:0] OP_QSUB  = 5'h05;
  localparam logic [4:0] OP_CMGT  = 5'h06;
  localparam logic [4:0] OP_CMGE  = 5'h07;
  localparam logic [4:0] OP_SHL   = 5'h08;
  localparam logic [4:0] OP_MAX   = 5'h0C;
  localparam logic [4:0] OP_MIN   = 5'h0D;
  localparam logic [4:0] OP_ABD   = 5'h0E;
  localparam logic [4:0] OP_ABA   = 5'h0F;
  localparam logic [4:0] OP_TST   = 5'h11;
  localparam logic [4:0] OP_QDMULH = 5'h16;

  // Element size codes
  localparam logic [1:0] SZ_B = 2'd0;
  localparam logic [1:0] SZ_H = 2'd1;
  localparam logic [1:0] SZ_S = 2'd2;
  localparam logic [1:0] SZ_D = 2'd3;

  function automatic logic [63:0] lane_mask(input logic [1:0] size);
    case (size)
      SZ_B:    lane_mask = 64'h0000_0000_0000_00FF;
      SZ_H:    lane_mask = 64'h0000_0000_0000_FFFF;
      SZ_S:    lane_mask = 64'h0000_0000_FFFF_FFFF;
      default: lane_mask = '1;
    endcase
  endfunction

  function automatic logic [63:0] sext(input logic [63:0] v, input logic [1:0] size);
    case (size)
      SZ_B:    sext = {{56{v[7]}}, v[7:0]};
      SZ_H:    sext = {{48{v[15]}}, v[15:0]};
      SZ_S:    sext = {{32{v[31]}}, v[31:0]};
      default: sext = v;
    endcase
  endfunction

  function automatic logic [63:0] asr(input logic [63:0] v, input logic [5:0] s);
    asr = $unsigned($signed(v) >>> s);
  endfunction

  // Saturating add or subtract on one lane
  function automatic logic [63:0] sat_addsub(input logic [63:0] a, input logic [63:0] b,
                                             input logic [1:0] size, input logic u,
                                             input logic sub);
    logic [63:0] mask;
    logic [64:0] s;
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] r;
    logic        ovf;
    logic        neg;
    mask = lane_mask(size);
    s = {1'b0, a} + {1'b0, b};
    x = sext(a, size);
    y = sext(b, size);
    r = sub ? x - y : x + y;
    ovf = sub ? (((x ^ y) & (x ^ r)) >> 63) != 64'd0
              : (((x ^ r) & (y ^ r)) >> 63) != 64'd0;
    neg = ovf ? x[63] : r[63];
    if (u) begin
      if (sub) sat_addsub = (a < b) ? 64'd0 : a - b;
      else sat_addsub = (s[64] || s[63:0] > mask) ? mask : s[63:0];
    end else if (!ovf && sext(r & mask, size) == r) begin
      sat_addsub = r & mask;
    end else begin
      sat_addsub = neg ? (((mask >> 1) + 64'd1) & mask) : (mask >> 1);
    end
  endfunction

  // One lane of every non-logic, non-multiply opcode
  function automatic logic [63:0] lane_alu(input logic [4:0] op, input logic [1:0] size,
                                           input logic u, input logic [63:0] a,
                                           input logic [63:0] b, input logic [63:0] acc);
    logic [63:0] mask;
    logic [7:0]  esize;
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] xh;
    logic [63:0] yh;
    logic        sgt;
    logic        slt_xy;
    logic        gt;
    logic [63:0] diff;
    logic [7:0]  byte_amt;
    logic [7:0]  rsh;
    logic [7:0]  ramt;
    mask = lane_mask(size);
    esize = 8'd8 << size;
    x = u ? a : sext(a, size);
    y = u ? b : sext(b, size);
    xh = u ? (x >> 1) : asr(x, 6'd1);
    yh = u ? (y >> 1) : asr(y, 6'd1);
    sgt = $signed(x) > $signed(y);
    slt_xy = $signed(x) < $signed(y);
    gt = u ? (x > y) : sgt;
    diff = gt ? x - y : y - x;
    byte_amt = b[7:0];
    rsh = 8'd0 - byte_amt;
    ramt = (rsh >= esize) ? esize - 8'd1 : rsh;
    case (op)
      OP_HADD:  lane_alu = (xh + yh + {63'd0, x[0] & y[0]}) & mask;
      OP_RHADD: lane_alu = (xh + yh + {63'd0, x[0] | y[0]}) & mask;
      OP_HSUB:  lane_alu = (xh - yh - {63'd0, ~x[0] & y[0]}) & mask;
      OP_QADD:  lane_alu = sat_addsub(a, b, size, u, 1'b0);
      OP_QSUB:  lane_alu = sat_addsub(a, b, size, u, 1'b1);
      OP_ABD:   lane_alu = diff & mask;
      OP_ABA:   lane_alu = (diff + acc) & mask;
      OP_CMGT:  lane_alu = (u ? (a > b) : sgt) ? mask : 64'd0;
      OP_CMGE:  lane_alu = (u ? (a >= b) : !slt_xy) ? mask : 64'd0;
      OP_TST:   lane_alu = (u ? (a == b) : ((a & b) != 64'd0)) ? mask : 64'd0;
      OP_SHL: begin
        if (!byte_amt[7]) begin
          lane_alu = (byte_amt >= esize) ? 64'd0 : ((a << byte_amt[5:0]) & mask);
        end else if (u) begin
          lane_alu = (rsh >= esize) ? 64'd0 : (a >> rsh[5:0]);
        end else begin
          lane_alu = asr(x, ramt[5:0]) & mask;
        end
      end
      OP_MAX:   lane_alu = (u ? (a > b) : sgt) ? a : b;
      OP_MIN:   lane_alu = (u ? (a < b) : slt_xy) ? a : b;
      default:  lane_alu = 64'd0;
    endcase
  endfunction

endpackage

/* design/simd_three_same_integer_alu_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// simd_three_same_integer_alu_core
// Lane-wise integer SIMD unit for the three-same class, three register stages.
// ----------------------------------------------------------------------------
//  channel | ports                                   | direction
//  in      | in_valid, in_stall, in_* operand fields | request in
//  out     | out_valid, out_stall, out_result_*      | result out
//
//  A request accepted into stage 1 moves on through stage 2 to the output stage,
//  where out_valid shows it until taken; one request per cycle is taken unless stalled.
//  Stage 1 registers operands and the lane products, stage 2 runs the lane
//  ALUs and the bitwise group, stage 3 rounds products and assembles.
//  A stalled output freezes the whole pipe; in_stall follows it directly.
//  rst_n is synchronous and clears the valid bits only.
`include "simd_three_same_integer_alu_core_assert.svh"

module simd_three_same_integer_alu_core
  import simd3_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [4:0]  in_req_type,
  input  logic [1:0]  in_elem_size,
  input  logic        in_unsigned_bit,
  input  logic        in_full_width,
  input  logic        in_scalar_form,
  input  logic [63:0] in_first_lo,
  input  logic [63:0] in_first_hi,
  input  logic [63:0] in_second_lo,
  input  logic [63:0] in_second_hi,
  input  logic [63:0] in_old_dest_lo,
  input  logic [63:0] in_old_dest_hi,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_result_lo,
  output logic [63:0] out_result_hi,
  output logic        out_status
);

  localparam int VecBits = VectorBytes * 8;

  typedef struct packed {
    logic [4:0] op;
    logic [1:0] size;
    logic       u;
    logic       q;
    logic       sc;
    logic       bad;
  } ctl_t;

  // Pipe advance
  logic adv;
  logic s1_v_r, s2_v_r, out_v_r;
  assign adv = !(out_v_r && out_stall);
  assign in_stall = !adv;

  // Stage 1: lane multipliers on the incoming operands
  logic [VecBits-1:0] src_n, src_m;
  logic [31:0]        p16_nxt [8];
  logic [63:0]        p32_nxt [4];
  logic [7:0]         mn16_nxt;
  logic [3:0]         mn32_nxt;

  assign src_n = {in_first_hi, in_first_lo};
  assign src_m = {in_second_hi, in_second_lo};

  for (genvar i = 0; i < 8; i++) begin : g_p16
    assign p16_nxt[i] = 32'($signed(src_n[16*i +: 16]) * $signed(src_m[16*i +: 16]));
    assign mn16_nxt[i] = (src_n[16*i +: 16] == 16'h8000) && (src_m[16*i +: 16] == 16'h8000);
  end
  for (genvar i = 0; i < 4; i++) begin : g_p32
    assign p32_nxt[i] = 64'($signed(src_n[32*i +: 32]) * $signed(src_m[32*i +: 32]));
    assign mn32_nxt[i] = (src_n[32*i +: 32] == 32'h8000_0000)
                      && (src_m[32*i +: 32] == 32'h8000_0000);
  end

  // Stage 1: operand capture
  logic [4:0]         s1_op_r;
  logic [1:0]         s1_size_r;
  logic               s1_u_r, s1_q_r, s1_sc_r;
  logic [VecBits-1:0] s1_n_r, s1_m_r, s1_d_r;
  logic [31:0]        s1_p16_r [8];
  logic [63:0]        s1_p32_r [4];
  logic [7:0]         s1_mn16_r;
  logic [3:0]         s1_mn32_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_valid;
    end
    if (adv) begin
      s1_op_r   <= in_req_type;
      s1_size_r <= in_elem_size;
      s1_u_r    <= in_unsigned_bit;
      s1_q_r    <= in_full_width;
      s1_sc_r   <= in_scalar_form;
      s1_n_r    <= src_n;
      s1_m_r    <= src_m;
      s1_d_r    <= {in_old_dest_hi, in_old_dest_lo};
      s1_p16_r  <= p16_nxt;
      s1_p32_r  <= p32_nxt;
      s1_mn16_r <= mn16_nxt;
      s1_mn32_r <= mn32_nxt;
    end
  end

  // Stage 2: decode, logic group, lane ALUs
  ctl_t               s2_ctl_nxt;
  logic [VecBits-1:0] bw_nxt;
  logic               known_op;

  always_comb begin
    case (s1_op_r)
      OP_HADD, OP_QADD, OP_RHADD, OP_LOGIC, OP_HSUB, OP_QSUB, OP_CMGT, OP_CMGE,
      OP_SHL, OP_MAX, OP_MIN, OP_ABD, OP_ABA, OP_TST, OP_QDMULH: known_op = 1'b1;
      default: known_op = 1'b0;
    endcase
    s2_ctl_nxt.op   = s1_op_r;
    s2_ctl_nxt.size = s1_size_r;
    s2_ctl_nxt.u    = s1_u_r;
    s2_ctl_nxt.q    = s1_q_r;
    s2_ctl_nxt.sc   = s1_sc_r;
    s2_ctl_nxt.bad  = !known_op
                   || (s1_op_r == OP_QDMULH && (s1_size_r == SZ_B || s1_size_r == SZ_D))
                   || (s1_op_r != OP_LOGIC && s1_size_r == SZ_D && !s1_q_r && !s1_sc_r);
  end

  // Bitwise group, sub-op in the unsigned bit and the size field
  always_comb begin
    if (!s1_u_r) begin
      case (s1_size_r)
        SZ_B:    bw_nxt = s1_n_r & s1_m_r;
        SZ_H:    bw_nxt = s1_n_r & ~s1_m_r;
        SZ_S:    bw_nxt = s1_n_r | s1_m_r;
        default: bw_nxt = s1_n_r | ~s1_m_r;
      endcase
    end else begin
      case (s1_size_r)
        SZ_B:    bw_nxt = s1_n_r ^ s1_m_r;
        SZ_H:    bw_nxt = (s1_n_r & s1_d_r) | (s1_m_r & ~s1_d_r);
        SZ_S:    bw_nxt = s1_d_r ^ ((s1_d_r ^ s1_n_r) & s1_m_r);
        default: bw_nxt = s1_d_r ^ ((s1_d_r ^ s1_n_r) & ~s1_m_r);
      endcase
    end
  end

  logic [VecBits-1:0] r8_nxt, r16_nxt, r32_nxt, r64_nxt;

  for (genvar i = 0; i < 16; i++) begin : g_b
    assign r8_nxt[8*i +: 8] = 8'(lane_alu(s1_op_r, SZ_B, s1_u_r,
        {56'd0, s1_n_r[8*i +: 8]}, {56'd0, s1_m_r[8*i +: 8]}, {56'd0, s1_d_r[8*i +: 8]}));
  end
  for (genvar i = 0; i < 8; i++) begin : g_h
    assign r16_nxt[16*i +: 16] = 16'(lane_alu(s1_op_r, SZ_H, s1_u_r,
        {48'd0, s1_n_r[16*i +: 16]}, {48'd0, s1_m_r[16*i +: 16]},
        {48'd0, s1_d_r[16*i +: 16]}));
  end
  for (genvar i = 0; i < 4; i++) begin : g_s
    assign r32_nxt[32*i +: 32] = 32'(lane_alu(s1_op_r, SZ_S, s1_u_r,
        {32'd0, s1_n_r[32*i +: 32]}, {32'd0, s1_m_r[32*i +: 32]},
        {32'd0, s1_d_r[32*i +: 32]}));
  end
  for (genvar i = 0; i < 2; i++) begin : g_d
    assign r64_nxt[64*i +: 64] = lane_alu(s1_op_r, SZ_D, s1_u_r,
        s1_n_r[64*i +: 64], s1_m_r[64*i +: 64], s1_d_r[64*i +: 64]);
  end

  ctl_t               s2_ctl_r;
  logic [VecBits-1:0] s2_bw_r, s2_r8_r, s2_r16_r, s2_r32_r, s2_r64_r;
  logic [31:0]        s2_p16_r [8];
  logic [63:0]        s2_p32_r [4];
  logic [7:0]         s2_mn16_r;
  logic [3:0]         s2_mn32_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r <= s1_v_r;
    end
    if (adv) begin
      s2_ctl_r  <= s2_ctl_nxt;
      s2_bw_r   <= bw_nxt;
      s2_r8_r   <= r8_nxt;
      s2_r16_r  <= r16_nxt;
      s2_r32_r  <= r32_nxt;
      s2_r64_r  <= r64_nxt;
      s2_p16_r  <= s1_p16_r;
      s2_p32_r  <= s1_p32_r;
      s2_mn16_r <= s1_mn16_r;
      s2_mn32_r <= s1_mn32_r;
    end
  end

  // Stage 3: product rounding, lane select, active-lane masking
  logic [VecBits-1:0] mul16, mul32, lanes_sel, byte_keep, res_nxt;
  logic [4:0]         nbytes;
  logic [31:0]        rnd16;
  logic [63:0]        rnd32;

  assign rnd16 = s2_ctl_r.u ? 32'h0000_4000 : 32'd0;
  assign rnd32 = s2_ctl_r.u ? 64'h0000_0000_4000_0000 : 64'd0;

  for (genvar i = 0; i < 8; i++) begin : g_mh
    logic [31:0] sum16;
    assign sum16 = s2_p16_r[i] + rnd16;
    assign mul16[16*i +: 16] = s2_mn16_r[i] ? 16'h7FFF : sum16[30:15];
  end
  for (genvar i = 0; i < 4; i++) begin : g_ms
    logic [63:0] sum32;
    assign sum32 = s2_p32_r[i] + rnd32;
    assign mul32[32*i +: 32] = s2_mn32_r[i] ? 32'h7FFF_FFFF : sum32[62:31];
  end

  assign nbytes = s2_ctl_r.sc ? (5'd1 << s2_ctl_r.size) : (s2_ctl_r.q ? 5'd16 : 5'd8);
  for (genvar j = 0; j < VectorBytes; j++) begin : g_keep
    assign byte_keep[8*j +: 8] = (5'(j) < nbytes) ? 8'hFF : 8'h00;
  end

  always_comb begin
    case (s2_ctl_r.size)
      SZ_B:    lanes_sel = s2_r8_r;
      SZ_H:    lanes_sel = (s2_ctl_r.op == OP_QDMULH) ? mul16 : s2_r16_r;
      SZ_S:    lanes_sel = (s2_ctl_r.op == OP_QDMULH) ? mul32 : s2_r32_r;
      default: lanes_sel = s2_r64_r;
    endcase
    if (s2_ctl_r.bad) res_nxt = '0;
    else if (s2_ctl_r.op == OP_LOGIC) res_nxt = s2_bw_r;
    else res_nxt = lanes_sel & byte_keep;
    if (!s2_ctl_r.q) res_nxt[VecBits-1:VecBits/2] = '0;
  end

  logic [VecBits-1:0] out_res_r;
  logic               out_bad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= s2_v_r;
    end
    if (adv) begin
      out_res_r <= res_nxt;
      out_bad_r <= s2_ctl_r.bad;
    end
  end

  assign out_valid     = out_v_r;
  assign out_result_lo = out_res_r[VecBits/2-1:0];
  assign out_result_hi = out_res_r[VecBits-1:VecBits/2];
  assign out_status    = out_bad_r;

  // Checks
  `S3_ASSERT_NOW(a_bad_zero, out_v_r && out_bad_r, out_res_r == '0,
                 "undefined request with nonzero result")
  `S3_ASSERT_NEXT(a_s1_moves, s1_v_r && adv, s2_v_r, "request lost between stage 1 and 2")
  `S3_ASSERT_NEXT(a_s2_moves, s2_v_r && adv, out_v_r, "request lost between stage 2 and 3")
  `S3_ASSERT_NEXT(a_bad_flag, s2_v_r && adv && s2_ctl_r.bad, out_bad_r,
                  "undefined flag dropped at output stage")

endmodule

/* tb/sv/simd3_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// simd3_checker
// Watches the request and result channels of the three-same SIMD core,
// predicts each result vector lane by lane and compares it in order.
// ----------------------------------------------------------------------------
module simd3_checker
  import simd3_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [4:0]  in_req_type,
  input  logic [1:0]  in_elem_size,
  input  logic        in_unsigned_bit,
  input  logic        in_full_width,
  input  logic        in_scalar_form,
  input  logic [63:0] in_first_lo,
  input  logic [63:0] in_first_hi,
  input  logic [63:0] in_second_lo,
  input  logic [63:0] in_second_hi,
  input  logic [63:0] in_old_dest_lo,
  input  logic [63:0] in_old_dest_hi,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [63:0] out_result_lo,
  input  logic [63:0] out_result_hi,
  input  logic        out_status,
  output int          mismatches,
  output int          vec_pending
);

  typedef struct packed {
    logic [63:0] lo;
    logic [63:0] hi;
    logic        status;
  } vec_result_t;

  vec_result_t vec_expected_q[$];

  function automatic logic [63:0] width_mask(input logic [1:0] size);
    case (size)
      SZ_B:    return 64'hFF;
      SZ_H:    return 64'hFFFF;
      SZ_S:    return 64'hFFFF_FFFF;
      default: return '1;
    endcase
  endfunction

  function automatic logic [63:0] sign_widen(input logic [63:0] v, input logic [1:0] size);
    case (size)
      SZ_B:    return {{56{v[7]}}, v[7:0]};
      SZ_H:    return {{48{v[15]}}, v[15:0]};
      SZ_S:    return {{32{v[31]}}, v[31:0]};
      default: return v;
    endcase
  endfunction

  function automatic logic [63:0] shr_arith(input logic [63:0] v, input int s);
    return $unsigned($signed(v) >>> (s & 63));
  endfunction

  function automatic logic [63:0] sat_lane(input logic [63:0] a, input logic [63:0] b,
                                           input logic [1:0] size, input logic u,
                                           input logic sub);
    logic [63:0] mask;
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] r;
    logic [64:0] sum;
    logic        ovf;
    logic        neg;
    mask = width_mask(size);
    if (u) begin
      if (sub) return (a < b) ? 64'd0 : a - b;
      sum = {1'b0, a} + {1'b0, b};
      return (sum[64] || sum[63:0] > mask) ? mask : sum[63:0];
    end
    x = sign_widen(a, size);
    y = sign_widen(b, size);
    r = sub ? x - y : x + y;
    ovf = sub ? (x[63] ^ y[63]) & (x[63] ^ r[63]) : (x[63] ^ r[63]) & (y[63] ^ r[63]);
    if (ovf) neg = x[63];
    else if (sign_widen(r & mask, size) != r) neg = r[63];
    else return r & mask;
    return neg ? ((mask >> 1) + 64'd1) & mask : mask >> 1;
  endfunction

  // One lane of any non-bitwise opcode
  function automatic logic [63:0] calc_lane(input logic [4:0] op, input logic [1:0] size,
                                            input logic u, input logic [63:0] a,
                                            input logic [63:0] b, input logic [63:0] acc,
                                            output logic bad);
    logic [63:0] mask;
    int          esize;
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] xh;
    logic [63:0] yh;
    logic        sgt;
    logic        slt;
    logic        gt;
    logic [63:0] diff;
    logic [63:0] prod;
    logic [63:0] minv;
    int          amt;
    int          rs;
    mask = width_mask(size);
    esize = 8 << size;
    x = u ? a : sign_widen(a, size);
    y = u ? b : sign_widen(b, size);
    xh = u ? x >> 1 : shr_arith(x, 1);
    yh = u ? y >> 1 : shr_arith(y, 1);
    sgt = $signed(x) > $signed(y);
    slt = $signed(x) < $signed(y);
    bad = 1'b0;
    case (op)
      OP_HADD:  return (xh + yh + {63'd0, x[0] & y[0]}) & mask;
      OP_RHADD: return (xh + yh + {63'd0, x[0] | y[0]}) & mask;
      OP_HSUB:  return (xh - yh - {63'd0, ~x[0] & y[0]}) & mask;
      OP_QADD:  return sat_lane(a, b, size, u, 1'b0);
      OP_QSUB:  return sat_lane(a, b, size, u, 1'b1);
      OP_ABD, OP_ABA: begin
        gt = u ? x > y : sgt;
        diff = gt ? x - y : y - x;
        if (op == OP_ABA) diff = diff + acc;
        return diff & mask;
      end
      OP_QDMULH: begin
        if (size == SZ_B || size == SZ_D) begin
          bad = 1'b1;
          return 64'd0;
        end
        minv = (mask >> 1) + 64'd1;
        if (a == minv && b == minv) return mask >> 1;
        prod = sign_widen(a, size) * sign_widen(b, size);
        if (u) prod = prod + (64'd1 << (esize - 2));
        return shr_arith(prod, esize - 1) & mask;
      end
      OP_CMGT: return (u ? a > b : sgt) ? mask : 64'd0;
      OP_CMGE: return (u ? a >= b : !slt) ? mask : 64'd0;
      OP_TST:  return (u ? a == b : (a & b) != 64'd0) ? mask : 64'd0;
      OP_SHL: begin
        amt = int'(b[7:0]);
        if (amt < 128) return (amt >= esize) ? 64'd0 : (a << amt) & mask;
        rs = 256 - amt;
        if (u) return (rs >= esize) ? 64'd0 : a >> rs;
        return shr_arith(x, (rs >= esize) ? esize - 1 : rs) & mask;
      end
      OP_MAX: return (u ? a > b : sgt) ? a : b;
      OP_MIN: return (u ? a < b : slt) ? a : b;
      default: begin
        bad = 1'b1;
        return 64'd0;
      end
    endcase
  endfunction

  function automatic vec_result_t predict_vector(input logic [4:0] op, input logic [1:0] size,
                                                 input logic u, input logic q, input logic sc,
                                                 input logic [63:0] n0, input logic [63:0] n1,
                                                 input logic [63:0] m0, input logic [63:0] m1,
                                                 input logic [63:0] d0, input logic [63:0] d1);
    logic [63:0] n [2];
    logic [63:0] m [2];
    logic [63:0] d [2];
    logic [63:0] r [2];
    logic [63:0] mask;
    logic [63:0] v;
    logic        bad;
    logic        lane_bad;
    int          lanes;
    int          off;
    int          w;
    int          sh;
    vec_result_t res;
    n[0] = n0; n[1] = n1; m[0] = m0; m[1] = m1; d[0] = d0; d[1] = d1;
    r[0] = '0; r[1] = '0;
    bad = 1'b0;
    mask = width_mask(size);
    if (op == OP_LOGIC) begin
      // Bitwise group on whole 64-bit words, scalar bit ignored
      for (int i = 0; i < 2; i++) begin
        if (i == 0 || q) begin
          case ({u, size})
            {1'b0, SZ_B}: r[i] = n[i] & m[i];
            {1'b0, SZ_H}: r[i] = n[i] & ~m[i];
            {1'b0, SZ_S}: r[i] = n[i] | m[i];
            {1'b0, SZ_D}: r[i] = n[i] | ~m[i];
            {1'b1, SZ_B}: r[i] = n[i] ^ m[i];
            {1'b1, SZ_H}: r[i] = (n[i] & d[i]) | (m[i] & ~d[i]);
            {1'b1, SZ_S}: r[i] = d[i] ^ ((d[i] ^ n[i]) & m[i]);
            default:      r[i] = d[i] ^ ((d[i] ^ n[i]) & ~m[i]);
          endcase
        end
      end
    end else if (size == SZ_D && !q && !sc) begin
      // reserved 1D form
      bad = 1'b1;
    end else begin
      lanes = sc ? 1 : ((q ? 16 : 8) >> size);
      for (int lane = 0; lane < 16; lane++) begin
        if (lane < lanes && !bad) begin
          off = lane << size;
          w = (off >> 3) & 1;
          sh = (off & 7) * 8;
          v = calc_lane(op, size, u, (n[w] >> sh) & mask, (m[w] >> sh) & mask,
                        (d[w] >> sh) & mask, lane_bad);
          bad = lane_bad;
          r[w] = (r[w] & ~(mask << sh)) | ((v << sh) & (mask << sh));
        end
      end
    end
    if (bad) begin
      r[0] = '0;
      r[1] = '0;
    end
    if (!q) r[1] = '0;
    res.lo = r[0];
    res.hi = r[1];
    res.status = bad;
    return res;
  endfunction

  // Predict on each accepted request, compare on each accepted result
  always @(posedge clk) begin
    vec_result_t exp_v;
    if (rst_n) begin
      if (in_valid && !in_stall)
        vec_expected_q.push_back(predict_vector(in_req_type, in_elem_size, in_unsigned_bit,
            in_full_width, in_scalar_form, in_first_lo, in_first_hi, in_second_lo,
            in_second_hi, in_old_dest_lo, in_old_dest_hi));
      if (out_valid && !out_stall) begin
        if (vec_expected_q.size() == 0) begin
          $display("%0t: unexpected result lo=%h hi=%h status=%b", $realtime,
                   out_result_lo, out_result_hi, out_status);
          mismatches <= mismatches + 1;
        end else begin
          exp_v = vec_expected_q.pop_front();
          if (exp_v.lo !== out_result_lo || exp_v.hi !== out_result_hi ||
              exp_v.status !== out_status) begin
            $display("%0t: mismatch expected lo=%h hi=%h status=%b actual lo=%h hi=%h status=%b",
                     $realtime, exp_v.lo, exp_v.hi, exp_v.status,
                     out_result_lo, out_result_hi, out_status);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
    vec_pending <= vec_expected_q.size();
  end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives directed and random three-same requests into the SIMD core under
// varying idle and stall pressure; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb
  import simd3_pkg::*;
();

  localparam int WatchdogLimit = 5000;
  localparam int HoldOffCycles = 80;

  // First floating-point opcode, outside the integer set
  localparam logic [4:0] OpFpFirst = 5'h18;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [4:0]  in_req_type = '0;
  logic [1:0]  in_elem_size = '0;
  logic        in_unsigned_bit = 1'b0;
  logic        in_full_width = 1'b0;
  logic        in_scalar_form = 1'b0;
  logic [63:0] in_first_lo = '0;
  logic [63:0] in_first_hi = '0;
  logic [63:0] in_second_lo = '0;
  logic [63:0] in_second_hi = '0;
  logic [63:0] in_old_dest_lo = '0;
  logic [63:0] in_old_dest_hi = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_result_lo;
  logic [63:0] out_result_hi;
  logic        out_status;
  int          mismatches;
  int          vec_pending;

  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          holdoff_seq = 0;
  int          holdoff_seen = 0;
  int          holdoff_left = 0;
  int          quiet_cycles = 0;

  simd_three_same_integer_alu_core u_dut (.*);

  simd3_checker u_checker (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver: random stall, or a long hold-off when requested
  always @(posedge clk) begin
    if (holdoff_seq != holdoff_seen) begin
      holdoff_seen = holdoff_seq;
      holdoff_left = HoldOffCycles;
    end
    if (holdoff_left > 0) begin
      holdoff_left = holdoff_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Watchdog on cycles with no traffic at all
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic send_req(input logic [4:0] op, input logic [1:0] size, input logic u,
                          input logic q, input logic sc,
                          input logic [63:0] n0, input logic [63:0] n1,
                          input logic [63:0] m0, input logic [63:0] m1,
                          input logic [63:0] d0, input logic [63:0] d1);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= op;
    in_elem_size <= size;
    in_unsigned_bit <= u;
    in_full_width <= q;
    in_scalar_form <= sc;
    in_first_lo <= n0;
    in_first_hi <= n1;
    in_second_lo <= m0;
    in_second_hi <= m1;
    in_old_dest_lo <= d0;
    in_old_dest_hi <= d1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Replicate one lane value across a 64-bit word
  function automatic logic [63:0] fill_lanes(input logic [63:0] v, input logic [1:0] size);
    logic [63:0] w;
    w = '0;
    for (int i = 0; i < 64; i += (8 << size)) w = w | (v << i);
    return w;
  endfunction

  function automatic logic [63:0] rand_word(input logic [1:0] size);
    logic [63:0] top;
    top = 64'd1 << ((8 << size) - 1);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return fill_lanes(top, size);
      3: return fill_lanes(top - 64'd1, size);
      4: return fill_lanes(64'($urandom_range(0, 300)), size);
      5: return fill_lanes(64'(256 - $urandom_range(0, 130)), size);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_random();
    logic [4:0] op;
    logic [1:0] size;
    case ($urandom_range(0, 15))
      0: op = OP_HADD;   1: op = OP_QADD;  2: op = OP_RHADD; 3: op = OP_LOGIC;
      4: op = OP_HSUB;   5: op = OP_QSUB;  6: op = OP_CMGT;  7: op = OP_CMGE;
      8: op = OP_SHL;    9: op = OP_MAX;   10: op = OP_MIN;  11: op = OP_ABD;
      12: op = OP_ABA;   13: op = OP_TST;  14: op = OP_QDMULH;
      default: op = 5'($urandom_range(0, 31));
    endcase
    size = 2'($urandom_range(0, 3));
    send_req(op, size, 1'($urandom), ($urandom_range(0, 3) != 0), ($urandom_range(0, 5) == 0),
             rand_word(size), rand_word(size), rand_word(size), rand_word(size),
             rand_word(size), rand_word(size));
  endtask

  initial begin
    logic [63:0] pat;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, a subset of the opcodes, bitwise sub-ops, reserved forms
    for (int s = 0; s < 4; s++) begin
      send_req(OP_LOGIC, 2'(s), 1'b0, 1'b1, 1'b0, 64'hF0F0_0F0F_FFFF_0000, '1,
               64'hFF00_FF00_1234_5678, '0, 64'hAAAA_5555_0000_FFFF, '1);
      send_req(OP_LOGIC, 2'(s), 1'b1, 1'b1, 1'b1, 64'hF0F0_0F0F_FFFF_0000, '1,
               64'hFF00_FF00_1234_5678, '0, 64'hAAAA_5555_0000_FFFF, '1);
    end
    pat = fill_lanes(64'h8000, SZ_H);
    send_req(OP_QDMULH, SZ_H, 1'b0, 1'b1, 1'b0, pat, pat, pat, pat, '0, '0);
    send_req(OP_QDMULH, SZ_S, 1'b1, 1'b1, 1'b0, '1, 64'h7FFF_FFFF_8000_0000,
             64'h7FFF_FFFF_0000_0001, '1, '0, '0);
    send_req(OP_QDMULH, SZ_B, 1'b0, 1'b1, 1'b0, '1, '1, '1, '1, '1, '1);
    send_req(OP_QDMULH, SZ_D, 1'b1, 1'b1, 1'b1, '1, '1, '1, '1, '1, '1);
    send_req(OP_QADD, SZ_D, 1'b0, 1'b0, 1'b0, '1, '1, '1, '1, '1, '1);
    send_req(OP_QADD, SZ_D, 1'b0, 1'b0, 1'b1, 64'h7FFF_FFFF_FFFF_FFFF, '0, 64'd1, '0, '0, '0);
    send_req(OP_QSUB, SZ_B, 1'b1, 1'b1, 1'b0, '0, 64'h7F80, '1, 64'h0180, '0, '0);
    send_req(OP_HADD, SZ_D, 1'b1, 1'b1, 1'b0, '1, '1, '1, 64'd1, '0, '0);
    send_req(OP_RHADD, SZ_D, 1'b0, 1'b1, 1'b0, 64'h8000_0000_0000_0000, '1,
             64'h8000_0000_0000_0001, 64'h7FFF_FFFF_FFFF_FFFF, '0, '0);
    send_req(OP_SHL, SZ_B, 1'b0, 1'b1, 1'b0, fill_lanes(64'h81, SZ_B), '1,
             64'h8081_F8F9_0807_0100, 64'hC0FF_7F40_3F09_80FE, '0, '0);
    send_req(OP_SHL, SZ_D, 1'b1, 1'b1, 1'b0, '1, '1, 64'h80, 64'hC1, '0, '0);
    send_req(OP_ABA, SZ_S, 1'b0, 1'b1, 1'b0, 64'h8000_0000_7FFF_FFFF, '1,
             64'h7FFF_FFFF_8000_0000, '0, '1, '1);
    send_req(OP_TST, SZ_H, 1'b0, 1'b0, 1'b1, 64'h0001, '1, 64'h0001, '1, '0, '0);
    send_req(OP_MIN, SZ_B, 1'b0, 1'b1, 1'b0, 64'h80_7F_00_FF, '0, 64'h7F_80_FF_00, '1, '0, '0);
    send_req(OpFpFirst, SZ_S, 1'b0, 1'b1, 1'b0, '1, '1, '1, '1, '1, '1);

    // Random phases under different idle and stall mixes
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      for (int i = 0; i < 435; i++) begin
        // long receiver hold-off while requests keep coming
        if (phase == 0 && i == 100) holdoff_seq = holdoff_seq + 1;
        // sender pauses until the pipe drains
        if (phase == 3 && i == 200) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (vec_pending != 0) @(posedge clk);
        end
        send_random();
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (vec_pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && vec_pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+design
design/simd3_pkg.sv
design/simd_three_same_integer_alu_core.sv
tb/sv/simd3_checker.sv
tb/sv/tb.sv
